// ===== design/jsu_pkg.sv =====
//==============================================================================
// jsu_pkg
// Shared types and codes for the JSON string unescaper: phases, result kinds,
// error codes and configuration limits.
//==============================================================================
`default_nettype none

package jsu_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  kind_t;
    typedef logic [3:0]  err_t;
    typedef logic [3:0]  phase_t;
    typedef logic [12:0] count_t;

    localparam int MAX_LENGTH_DEFAULT = 4096;
    localparam int CFG_MAX            = 8191;

    localparam phase_t PH_IDLE   = 4'd0;
    localparam phase_t PH_STR    = 4'd1;
    localparam phase_t PH_ESC    = 4'd2;
    localparam phase_t PH_HEX_HI = 4'd3;
    localparam phase_t PH_SUR_BS = 4'd4;
    localparam phase_t PH_SUR_U  = 4'd5;
    localparam phase_t PH_HEX_LO = 4'd6;

    localparam kind_t K_BYTE = 2'd0;
    localparam kind_t K_DONE = 2'd1;
    localparam kind_t K_ERR  = 2'd2;

    localparam err_t E_NONE         = 4'd0;
    localparam err_t E_NO_QUOTE     = 4'd1;
    localparam err_t E_CONTROL      = 4'd2;
    localparam err_t E_OPEN_ESC     = 4'd3;
    localparam err_t E_UNKNOWN_ESC  = 4'd4;
    localparam err_t E_INCOMPL_HEX  = 4'd5;
    localparam err_t E_BAD_HEX      = 4'd6;
    localparam err_t E_LOW_SUR      = 4'd7;
    localparam err_t E_MISSING_LOW  = 4'd8;
    localparam err_t E_BAD_LOW      = 4'd9;
    localparam err_t E_UNTERMINATED = 4'd10;
    localparam err_t E_SIZE         = 4'd11;

    localparam byte_t CH_QUOTE = 8'h22;
    localparam byte_t CH_BSL   = 8'h5C;
    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_U     = 8'h75;

    localparam logic [0:0] REG_MAX_OUTPUT_BYTES = 1'b0;

endpackage

`default_nettype wire

// ===== design/json_string_unescape_utf8.sv =====
//==============================================================================
// json_string_unescape_utf8
// Decodes one quoted JSON string per run from a byte stream into UTF-8 bytes,
// with escape and surrogate handling, length limit and error reporting.
//==============================================================================
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] data_byte, tuser input_ended
// m_axis    out        tdata[7:0] out_byte, tdata[11:8] err_code, tuser kind,
//                      tlast last
// apb       in/out     max_output_bytes at byte address 0
//
// One input byte is accepted per cycle while the buffer can take it; it updates
// the decoder state and loads the result buffer in that same edge. A code point
// that encodes to n UTF-8 bytes gives n entries on m_axis, and input waits for them.
// Input is taken while the buffer is empty or its final entry leaves this
// cycle; m_axis stalls hold the buffer and back-pressure s_axis.
// Reset is asynchronous, active low, and leaves the decoder idle.
//==============================================================================
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int MAX_LENGTH = jsu_pkg::MAX_LENGTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire jsu_pkg::byte_t s_axis_tdata,   // [7:0] data_byte
    input  wire logic           s_axis_tuser,   // [0] input_ended
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [7:0] out_byte, [11:8] err_code
    output jsu_pkg::kind_t      m_axis_tuser,   // [1:0] kind
    output logic                m_axis_tlast,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import jsu_pkg::*;

    localparam int     CAP_INT   = (MAX_LENGTH > CFG_MAX) ? CFG_MAX : MAX_LENGTH;
    localparam count_t LIMIT_CAP = count_t'(CAP_INT);

    count_t          max_reg;
    phase_t          phase_reg, phase_next;
    count_t          out_count_reg, out_count_next;
    logic [15:0]     hex_reg, hex_next;
    logic [9:0]      high_reg, high_next;
    logic [1:0]      dcount_reg, dcount_next;
    logic            bad_reg, bad_next;

    logic [2:0]      buf_cnt_reg;
    kind_t           buf_kind_reg;
    err_t            buf_err_reg;
    logic [3:0][7:0] buf_bytes_reg;

    logic [2:0]      res_cnt;
    kind_t           res_kind;
    err_t            res_err;
    logic [3:0][7:0] res_bytes;

    logic            s_accept;
    logic            m_take;
    logic            cfg_write;
    count_t          limit;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_MAX_OUTPUT_BYTES);
    assign prdata    = (paddr[2] == REG_MAX_OUTPUT_BYTES) ? {19'd0, max_reg} : 32'd0;
    assign limit     = (max_reg > LIMIT_CAP) ? LIMIT_CAP : max_reg;

    assign m_axis_tvalid = (buf_cnt_reg != 3'd0);
    assign m_axis_tdata  = {4'd0, buf_err_reg, buf_bytes_reg[0]};
    assign m_axis_tuser  = buf_kind_reg;
    assign m_axis_tlast  = (buf_cnt_reg == 3'd1);
    assign m_take        = m_axis_tvalid & m_axis_tready;
    assign s_axis_tready = (buf_cnt_reg == 3'd0) | ((buf_cnt_reg == 3'd1) & m_axis_tready);
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        byte_t       c;
        logic        ended;
        logic [3:0]  dval;
        logic        not_digit;
        logic [15:0] new_hex;
        logic        new_bad;
        logic        emit;
        logic [20:0] cp;
        logic        fail;
        err_t        ecode;
        logic [2:0]  n;
        logic [3:0][7:0] enc;
        logic [13:0] total;

        c         = s_axis_tdata;
        ended     = s_axis_tuser;
        dval      = 4'd0;
        not_digit = 1'b0;
        if (c inside {[8'h30:8'h39]})
        begin
            dval = c[3:0];
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            dval = 4'(c[3:0] + 4'd9);
        end
        else
        begin
            not_digit = 1'b1;
        end
        new_hex = {hex_reg[11:0], dval};
        new_bad = bad_reg | not_digit;

        phase_next     = phase_reg;
        out_count_next = out_count_reg;
        hex_next       = hex_reg;
        high_next      = high_reg;
        dcount_next    = dcount_reg;
        bad_next       = bad_reg;
        emit           = 1'b0;
        cp             = 21'd0;
        fail           = 1'b0;
        ecode          = E_NONE;
        res_cnt        = 3'd0;
        res_kind       = K_BYTE;
        res_err        = E_NONE;
        res_bytes      = '0;

        case (phase_reg)
            PH_STR:
            begin
                if (ended)
                begin
                    fail  = 1'b1;
                    ecode = E_UNTERMINATED;
                end
                else if (c == CH_QUOTE)
                begin
                    phase_next = PH_IDLE;
                    res_cnt    = 3'd1;
                    res_kind   = K_DONE;
                end
                else if (c < 8'h20)
                begin
                    fail  = 1'b1;
                    ecode = E_CONTROL;
                end
                else if (c == CH_BSL)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    emit = 1'b1;
                    cp   = {13'd0, c};
                end
            end
            PH_ESC:
            begin
                if (ended)
                begin
                    fail  = 1'b1;
                    ecode = E_OPEN_ESC;
                end
                else
                begin
                    phase_next = PH_STR;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH:
                        begin
                            emit = 1'b1;
                            cp   = {13'd0, c};
                        end
                        8'h62:
                        begin
                            emit = 1'b1;
                            cp   = 21'h08;
                        end
                        8'h66:
                        begin
                            emit = 1'b1;
                            cp   = 21'h0C;
                        end
                        8'h6E:
                        begin
                            emit = 1'b1;
                            cp   = 21'h0A;
                        end
                        8'h72:
                        begin
                            emit = 1'b1;
                            cp   = 21'h0D;
                        end
                        8'h74:
                        begin
                            emit = 1'b1;
                            cp   = 21'h09;
                        end
                        CH_U:
                        begin
                            hex_next    = 16'd0;
                            dcount_next = 2'd0;
                            bad_next    = 1'b0;
                            phase_next  = PH_HEX_HI;
                        end
                        default:
                        begin
                            fail  = 1'b1;
                            ecode = E_UNKNOWN_ESC;
                        end
                    endcase
                end
            end
            PH_HEX_HI, PH_HEX_LO:
            begin
                if (ended)
                begin
                    fail  = 1'b1;
                    ecode = E_INCOMPL_HEX;
                end
                else
                begin
                    hex_next = new_hex;
                    bad_next = new_bad;
                    if (dcount_reg != 2'd3)
                    begin
                        dcount_next = 2'(dcount_reg + 2'd1);
                    end
                    else if (new_bad)
                    begin
                        fail  = 1'b1;
                        ecode = E_BAD_HEX;
                    end
                    else if (phase_reg == PH_HEX_HI)
                    begin
                        if (new_hex[15:10] == 6'b110111)
                        begin
                            fail  = 1'b1;
                            ecode = E_LOW_SUR;
                        end
                        else if (new_hex[15:10] != 6'b110110)
                        begin
                            phase_next = PH_STR;
                            emit       = 1'b1;
                            cp         = {5'd0, new_hex};
                        end
                        else
                        begin
                            high_next  = new_hex[9:0];
                            phase_next = PH_SUR_BS;
                        end
                    end
                    else if (new_hex[15:10] != 6'b110111)
                    begin
                        fail  = 1'b1;
                        ecode = E_BAD_LOW;
                    end
                    else
                    begin
                        phase_next = PH_STR;
                        emit       = 1'b1;
                        cp         = 21'h10000 + {1'b0, high_reg, new_hex[9:0]};
                    end
                end
            end
            PH_SUR_BS:
            begin
                if (ended || c != CH_BSL)
                begin
                    fail  = 1'b1;
                    ecode = E_MISSING_LOW;
                end
                else
                begin
                    phase_next = PH_SUR_U;
                end
            end
            PH_SUR_U:
            begin
                if (ended || c != CH_U)
                begin
                    fail  = 1'b1;
                    ecode = E_MISSING_LOW;
                end
                else
                begin
                    hex_next    = 16'd0;
                    dcount_next = 2'd0;
                    bad_next    = 1'b0;
                    phase_next  = PH_HEX_LO;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (ended)
                begin
                    fail  = 1'b1;
                    ecode = E_NO_QUOTE;
                end
                else if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A})
                begin
                    phase_next = PH_IDLE;
                end
                else if (c != CH_QUOTE)
                begin
                    fail  = 1'b1;
                    ecode = E_NO_QUOTE;
                end
                else
                begin
                    out_count_next = '0;
                    phase_next     = PH_STR;
                end
            end
        endcase

        enc = '0;
        if (cp <= 21'h7F)
        begin
            n      = 3'd1;
            enc[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF)
        begin
            n      = 3'd2;
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF)
        begin
            n      = 3'd3;
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            n      = 3'd4;
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
        end
        total = {1'b0, out_count_reg} + {11'd0, n};

        if (emit)
        begin
            if (total > {1'b0, limit})
            begin
                fail  = 1'b1;
                ecode = E_SIZE;
            end
            else
            begin
                res_cnt        = n;
                res_bytes      = enc;
                out_count_next = total[12:0];
            end
        end

        if (fail)
        begin
            phase_next = PH_IDLE;
            res_cnt    = 3'd1;
            res_kind   = K_ERR;
            res_err    = ecode;
            res_bytes  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= LIMIT_CAP;
            phase_reg     <= PH_IDLE;
            out_count_reg <= '0;
            hex_reg       <= '0;
            high_reg      <= '0;
            dcount_reg    <= '0;
            bad_reg       <= 1'b0;
            buf_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_reg <= pwdata[12:0];
            end
            if (s_accept)
            begin
                phase_reg     <= phase_next;
                out_count_reg <= out_count_next;
                hex_reg       <= hex_next;
                high_reg      <= high_next;
                dcount_reg    <= dcount_next;
                bad_reg       <= bad_next;
                buf_cnt_reg   <= res_cnt;
            end
            else if (m_take)
            begin
                buf_cnt_reg <= 3'(buf_cnt_reg - 3'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            buf_kind_reg  <= res_kind;
            buf_err_reg   <= res_err;
            buf_bytes_reg <= res_bytes;
        end
        else if (m_take)
        begin
            buf_bytes_reg <= {8'h00, buf_bytes_reg[3:1]};
        end
    end

    a_buf_depth: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= 3'd4)
        else $error("result buffer holds more than four entries");

    a_multi_is_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_cnt_reg > 3'd1) |-> (buf_kind_reg == K_BYTE))
        else $error("multi-entry result is not a byte run");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((buf_kind_reg == K_ERR) == (buf_err_reg != E_NONE)))
        else $error("error code does not match result kind");

    a_done_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && buf_kind_reg != K_BYTE) |-> m_axis_tlast)
        else $error("done or error transaction not marked last");

endmodule

`default_nettype wire

// ===== sim/json_string_unescape_utf8_test.sv =====
//==============================================================================
// json_string_unescape_utf8_test
// Drives byte streams into the JSON string unescaper and checks every decoded
// byte, done marker and error code against a cycle-free decoder written here,
// or against typed rows of the short directed table that comes first. Random
// strings follow: mostly well-formed with random escapes and surrogate pairs,
// the rest broken or noise, under several length limits and three stall patterns.
//==============================================================================
module json_string_unescape_utf8_test;

    import jsu_pkg::*;

    typedef struct packed {
        kind_t kind;
        byte_t data;
        err_t  err;
        logic  last;
    } result_t;

    typedef struct packed {
        byte_t data;
        logic  ended;
        logic  typed;
        kind_t kind;
        byte_t obyte;
        err_t  err;
    } row_t;

    localparam int MAX_LEN        = MAX_LENGTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int ITEMS_PER_STEP = 18;

    localparam logic [2:0] ADDR_MAX_OUT = {REG_MAX_OUTPUT_BYTES, 2'b00};
    localparam logic [2:0] ADDR_UNUSED  = 3'd4;

    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_LF    = 8'h0A;

    localparam byte_t WS_CHARS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    localparam byte_t SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, "b", "f", "n", "r", "t"};

    localparam int SRC_IDLE [3] = '{38, 78, 0};
    localparam int DST_IDLE [3] = '{78, 38, 0};

    localparam logic [31:0] LIMITS [12] = '{
        32'd1, 32'd0, 32'hFFFF_E003, 32'd8191,
        32'd6, 32'd4096, 32'd2, 32'd4095,
        32'd5, 32'd8190, 32'd9, 32'd4097
    };

    localparam row_t DIRECTED [25] = '{
        '{8'hFF,    1'b1, 1'b1, K_ERR,  8'h00, E_NO_QUOTE},
        '{CH_SPACE, 1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{CH_TAB,   1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"x",      1'b0, 1'b1, K_ERR,  8'h00, E_NO_QUOTE},
        '{CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{8'h00,    1'b0, 1'b1, K_ERR,  8'h00, E_CONTROL},
        '{CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{8'hFF,    1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{CH_BSL,   1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{CH_U,     1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"D",      1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"8",      1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"3",      1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"d",      1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{CH_BSL,   1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{CH_U,     1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"D",      1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"E",      1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"0",      1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"0",      1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{CH_BSL,   1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{8'h00,    1'b1, 1'b1, K_ERR,  8'h00, E_OPEN_ESC},
        '{CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, E_NONE},
        '{"A",      1'b0, 1'b1, K_BYTE, 8'h41, E_NONE},
        '{CH_QUOTE, 1'b0, 1'b1, K_DONE, 8'h00, E_NONE}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    byte_t       s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    kind_t       m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    json_string_unescape_utf8 u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int      src_idle_pct = 0;
    int      dst_idle_pct = 0;
    int      fail_count   = 0;
    int      stall_count  = 0;
    int      items_sent   = 0;

    result_t decoded_q [$];
    result_t step_out [$];
    row_t    stim_q [$];

    int      cfg_max_reg;
    phase_t  dec_phase;
    int      dec_count;
    int      dec_hex;
    int      dec_high;
    int      dec_digits;
    bit      dec_bad;

    // ---------------------------------------------------------------- decoder

    function automatic void push_result(kind_t k, byte_t b, err_t e);
        result_t r;
        r.kind = k;
        r.data = b;
        r.err  = e;
        r.last = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void fail_decode(err_t e);
        dec_phase = PH_IDLE;
        push_result(K_ERR, 8'h00, e);
    endfunction

    function automatic void emit_code_point(int cp);
        int b [4];
        int n;
        int lim;
        if (cp <= 'h7F)
        begin
            b[0] = cp;
            n = 1;
        end
        else if (cp <= 'h7FF)
        begin
            b[0] = 'hC0 | (cp >> 6);
            b[1] = 'h80 | (cp & 'h3F);
            n = 2;
        end
        else if (cp <= 'hFFFF)
        begin
            b[0] = 'hE0 | (cp >> 12);
            b[1] = 'h80 | ((cp >> 6) & 'h3F);
            b[2] = 'h80 | (cp & 'h3F);
            n = 3;
        end
        else
        begin
            b[0] = 'hF0 | (cp >> 18);
            b[1] = 'h80 | ((cp >> 12) & 'h3F);
            b[2] = 'h80 | ((cp >> 6) & 'h3F);
            b[3] = 'h80 | (cp & 'h3F);
            n = 4;
        end
        lim = (cfg_max_reg > MAX_LEN) ? MAX_LEN : cfg_max_reg;
        if (dec_count + n > lim)
            fail_decode(E_SIZE);
        else
        begin
            for (int i = 0; i < n; i++)
                push_result(K_BYTE, byte_t'(b[i]), E_NONE);
            dec_count = dec_count + n;
        end
    endfunction

    function automatic void start_quad(phase_t next);
        dec_hex    = 0;
        dec_digits = 0;
        dec_bad    = 1'b0;
        dec_phase  = next;
    endfunction

    function automatic bit is_hex(byte_t c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit take_hex_slot(byte_t c);
        int d;
        d = 0;
        if (c >= "0" && c <= "9")
            d = int'(c - "0");
        else if (c >= "a" && c <= "f")
            d = int'(c - "a") + 10;
        else if (c >= "A" && c <= "F")
            d = int'(c - "A") + 10;
        else
            dec_bad = 1'b1;
        dec_hex = ((dec_hex << 4) | d) & 'hFFFF;
        if (dec_digits == 3)
            return 1'b1;
        dec_digits = dec_digits + 1;
        return 1'b0;
    endfunction

    function automatic void decode_step(byte_t c, logic ended);
        result_t r;
        step_out.delete();
        case (dec_phase)
            PH_STR:
            begin
                if (ended)
                    fail_decode(E_UNTERMINATED);
                else if (c == CH_QUOTE)
                begin
                    dec_phase = PH_IDLE;
                    push_result(K_DONE, 8'h00, E_NONE);
                end
                else if (c < CH_SPACE)
                    fail_decode(E_CONTROL);
                else if (c == CH_BSL)
                    dec_phase = PH_ESC;
                else
                    emit_code_point(int'(c));
            end
            PH_ESC:
            begin
                if (ended)
                    fail_decode(E_OPEN_ESC);
                else
                begin
                    dec_phase = PH_STR;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: emit_code_point(int'(c));
                        "b": emit_code_point('h08);
                        "f": emit_code_point('h0C);
                        "n": emit_code_point('h0A);
                        "r": emit_code_point('h0D);
                        "t": emit_code_point('h09);
                        CH_U: start_quad(PH_HEX_HI);
                        default: fail_decode(E_UNKNOWN_ESC);
                    endcase
                end
            end
            PH_HEX_HI:
            begin
                if (ended)
                    fail_decode(E_INCOMPL_HEX);
                else if (take_hex_slot(c))
                begin
                    if (dec_bad)
                        fail_decode(E_BAD_HEX);
                    else if (dec_hex >= 'hDC00 && dec_hex <= 'hDFFF)
                        fail_decode(E_LOW_SUR);
                    else if (dec_hex < 'hD800 || dec_hex > 'hDBFF)
                    begin
                        dec_phase = PH_STR;
                        emit_code_point(dec_hex);
                    end
                    else
                    begin
                        dec_high  = dec_hex - 'hD800;
                        dec_phase = PH_SUR_BS;
                    end
                end
            end
            PH_SUR_BS:
            begin
                if (ended || c != CH_BSL)
                    fail_decode(E_MISSING_LOW);
                else
                    dec_phase = PH_SUR_U;
            end
            PH_SUR_U:
            begin
                if (ended || c != CH_U)
                    fail_decode(E_MISSING_LOW);
                else
                    start_quad(PH_HEX_LO);
            end
            PH_HEX_LO:
            begin
                if (ended)
                    fail_decode(E_INCOMPL_HEX);
                else if (take_hex_slot(c))
                begin
                    if (dec_bad)
                        fail_decode(E_BAD_HEX);
                    else if (dec_hex < 'hDC00 || dec_hex > 'hDFFF)
                        fail_decode(E_BAD_LOW);
                    else
                    begin
                        dec_phase = PH_STR;
                        emit_code_point('h10000 + (dec_high << 10) + (dec_hex - 'hDC00));
                    end
                end
            end
            default:
            begin
                dec_phase = PH_IDLE;
                if (ended)
                    fail_decode(E_NO_QUOTE);
                else if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_LF)
                begin
                    if (c != CH_QUOTE)
                        fail_decode(E_NO_QUOTE);
                    else
                    begin
                        dec_count = 0;
                        dec_phase = PH_STR;
                    end
                end
            end
        endcase
        if (step_out.size() != 0)
        begin
            r = step_out[step_out.size() - 1];
            r.last = 1'b1;
            step_out[step_out.size() - 1] = r;
        end
    endfunction

    // -------------------------------------------------------------- stimulus

    function automatic void add_byte(byte_t b);
        row_t r;
        r = '0;
        r.data = b;
        stim_q.insert(stim_q.size(), r);
    endfunction

    function automatic void add_end();
        row_t r;
        r = '0;
        r.data  = byte_t'($urandom);
        r.ended = 1'b1;
        stim_q.insert(stim_q.size(), r);
    endfunction

    function automatic byte_t hex_digit(int n);
        if (n < 10)
            return "0" + byte_t'(n);
        return ($urandom_range(1) ? "a" : "A") + byte_t'(n - 10);
    endfunction

    function automatic byte_t non_hex();
        byte_t b;
        do
            b = byte_t'($urandom);
        while (is_hex(b));
        return b;
    endfunction

    function automatic bit known_escape(byte_t c);
        foreach (SIMPLE_ESC[i])
            if (SIMPLE_ESC[i] == c)
                return 1'b1;
        return c == CH_U;
    endfunction

    function automatic void add_u();
        add_byte(CH_BSL);
        add_byte(CH_U);
    endfunction

    function automatic void add_quad(int v);
        for (int i = 3; i >= 0; i--)
            add_byte(hex_digit((v >> (4 * i)) & 'hF));
    endfunction

    function automatic void add_slots(int n, int bad_pos);
        for (int i = 0; i < n; i++)
            if (i == bad_pos)
                add_byte(($urandom_range(2) == 0) ? CH_QUOTE : non_hex());
            else
                add_byte(hex_digit($urandom_range(15)));
    endfunction

    function automatic int bmp_value();
        int v;
        case ($urandom_range(4))
            0: v = $urandom_range('h7F);
            1: v = $urandom_range('h7FF, 'h80);
            2: v = ($urandom_range(1) == 0) ? 'h0000 : 'hFFFF;
            default:
            begin
                do
                    v = $urandom_range('hFFFF, 'h800);
                while (v >= 'hD800 && v <= 'hDFFF);
            end
        endcase
        return v;
    endfunction

    function automatic void add_piece();
        byte_t b;
        case ($urandom_range(6))
            0, 1:
            begin
                do
                    b = byte_t'($urandom_range(8'h7E, 8'h20));
                while (b == CH_QUOTE || b == CH_BSL);
                add_byte(b);
            end
            2: add_byte(byte_t'($urandom_range(8'hFF, 8'h80)));
            3:
            begin
                add_byte(CH_BSL);
                add_byte(SIMPLE_ESC[$urandom_range(7)]);
            end
            4:
            begin
                add_u();
                add_quad(bmp_value());
            end
            default:
            begin
                add_u();
                add_quad($urandom_range('hDBFF, 'hD800));
                add_u();
                add_quad($urandom_range('hDFFF, 'hDC00));
            end
        endcase
    endfunction

    function automatic void add_string(int max_pieces, bit closed);
        repeat ($urandom_range(2))
            add_byte(WS_CHARS[$urandom_range(3)]);
        add_byte(CH_QUOTE);
        repeat ($urandom_range(max_pieces))
            add_piece();
        if (closed)
            add_byte(CH_QUOTE);
    endfunction

    function automatic void add_fragment();
        int    pick;
        int    v;
        byte_t b;
        pick = $urandom_range(99);
        if (pick < 55)
            add_string(6, 1'b1);
        else if (pick < 88)
        begin
            add_string(3, 1'b0);
            case ($urandom_range(9))
                0: add_byte(byte_t'($urandom_range(8'h1F)));
                1:
                begin
                    add_byte(CH_BSL);
                    b = byte_t'($urandom);
                    if (known_escape(b))
                        b = "q";
                    add_byte(b);
                end
                2:
                begin
                    add_u();
                    add_slots(4, $urandom_range(3));
                end
                3:
                begin
                    add_u();
                    add_slots($urandom_range(3), $urandom_range(3));
                    add_end();
                end
                4:
                begin
                    add_u();
                    add_quad($urandom_range('hDFFF, 'hDC00));
                end
                5:
                begin
                    add_u();
                    add_quad($urandom_range('hDBFF, 'hD800));
                    case ($urandom_range(3))
                        0:
                        begin
                            do
                                b = byte_t'($urandom);
                            while (b == CH_BSL);
                            add_byte(b);
                        end
                        1: add_end();
                        2:
                        begin
                            add_byte(CH_BSL);
                            do
                                b = byte_t'($urandom);
                            while (b == CH_U);
                            add_byte(b);
                        end
                        default:
                        begin
                            add_byte(CH_BSL);
                            add_end();
                        end
                    endcase
                end
                6:
                begin
                    add_u();
                    add_quad($urandom_range('hDBFF, 'hD800));
                    add_u();
                    do
                        v = $urandom_range('hFFFF);
                    while (v >= 'hDC00 && v <= 'hDFFF);
                    add_quad(v);
                end
                7:
                begin
                    add_byte(CH_BSL);
                    add_end();
                end
                8: add_end();
                default:
                begin
                    add_u();
                    add_quad($urandom_range('hDBFF, 'hD800));
                    add_u();
                    add_slots(4, $urandom_range(3));
                end
            endcase
        end
        else
            repeat ($urandom_range(3, 1))
            begin
                if ($urandom_range(7) == 0)
                    add_end();
                else
                    add_byte(byte_t'($urandom));
            end
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_row(input row_t r);
        result_t typed_res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.data;
        s_axis_tuser  <= r.ended;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_step(r.data, r.ended);
        if (r.typed)
        begin
            typed_res.kind = r.kind;
            typed_res.data = r.obyte;
            typed_res.err  = r.err;
            typed_res.last = 1'b1;
            decoded_q.insert(decoded_q.size(), typed_res);
        end
        else
            foreach (step_out[i])
                decoded_q.insert(decoded_q.size(), step_out[i]);
    endtask

    task automatic feed_stimulus();
        while (stim_q.size() != 0)
        begin
            send_row(stim_q.pop_front());
            items_sent++;
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_MAX_OUT)
            cfg_max_reg = int'(value & 32'h1FFF);
        // read back the limit register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_OUT;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(cfg_max_reg))
        begin
            $display("%0t: max_output_bytes readback mismatch, expected %h, actual %h",
                     $time, 32'(cfg_max_reg), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // -------------------------------------------------------------- receiving

    function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("json_string_unescape_utf8 verification failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual tdata %h tuser %h tlast %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
                    check_field("out_byte", 16'(want.data), 16'(m_axis_tdata[7:0]));
                    check_field("err_code", 16'(want.err), 16'(m_axis_tdata[11:8]));
                    check_field("tdata pad", 16'h0000, 16'(m_axis_tdata[15:12]));
                    check_field("last", 16'(want.last), 16'(m_axis_tlast));
                end
            end
        end
    end

    // ------------------------------------------------------------------- main

    initial
    begin : main
        int m;
        int s;
        cfg_max_reg = (MAX_LEN > CFG_MAX) ? CFG_MAX : MAX_LEN;
        dec_phase   = PH_IDLE;
        dec_count   = 0;
        dec_hex     = 0;
        dec_high    = 0;
        dec_digits  = 0;
        dec_bad     = 1'b0;
        src_idle_pct = SRC_IDLE[0];
        dst_idle_pct = DST_IDLE[0];
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_row(DIRECTED[i]);
        wait_idle();
        write_config(ADDR_UNUSED, $urandom);

        items_sent = 0;
        for (m = 0; m < 3; m++)
        begin
            src_idle_pct = SRC_IDLE[m];
            dst_idle_pct = DST_IDLE[m];
            for (s = 0; s < 4; s++)
            begin
                wait_idle();
                write_config(ADDR_MAX_OUT, LIMITS[m * 4 + s]);
                while (items_sent < ITEMS_PER_STEP * (m * 4 + s + 1))
                begin
                    add_fragment();
                    feed_stimulus();
                end
                // at random, leave a string open across the next limit change
                if ($urandom_range(1) == 1)
                begin
                    add_string(4, 1'b0);
                    feed_stimulus();
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("json_string_unescape_utf8 verification clean");
        else
            $display("json_string_unescape_utf8 verification failed");
        $finish;
    end

endmodule
